// File: src/hrp_pkg.sv
// Shared types, character codes and helpers for the hex record parser.
// Used by hrp_decode and hex_record_parser_core; no dependencies.
package hrp_pkg;

	// Character codes
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// Reset value of the base address register
	localparam logic [15:0] BASE_RESET = 16'h4000;

	// Line position saturates here
	localparam logic [9:0] POS_MAX = 10'd1023;

	// Largest word count the high-water mark can hold
	localparam int HW_LIMIT = 16383;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	// Record class after the type byte
	typedef enum logic [1:0] {
		REC_MUTED = 2'd0,
		REC_DATA  = 2'd1,
		REC_EOF   = 2'd2
	} rec_kind_t;

	typedef struct packed {
		logic       receiving;
		logic [7:0] rx_char;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_value;
		logic [15:0] byte_address;
		logic [13:0] high_water_words;
	} out_item_t;

	// Parser state carried from one character to the next
	typedef struct packed {
		logic [9:0]  char_position;
		logic [7:0]  rec_length;
		logic [15:0] record_offset;
		rec_kind_t   record_kind;
		logic [7:0]  checksum_sum;
		logic [3:0]  pending_nibble;
		logic [8:0]  data_char_index;
		logic        aborted;
		logic [13:0] high_water;
	} parse_state_t;

	// Decode one ASCII hex digit; anything else reads as zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

endpackage

// File: src/hrp_decode.sv
// Per-character record decoder: next parser state and optional result.
// Pure combinational logic; depends on hrp_pkg.
module hrp_decode import hrp_pkg::*; #(
	parameter logic [13:0] HW_CAP = 14'd8192
) (
	input  in_item_t     item,
	input  parse_state_t cur,
	input  logic [15:0]  base_address,
	output parse_state_t nxt,
	output logic         res_valid,
	output out_item_t    res
);

	logic [7:0]  c;
	logic [9:0]  pos;
	logic [3:0]  nib;
	logic        eol;
	logic [7:0]  pair;
	logic [8:0]  digits;
	logic [15:0] shifted_offset;
	logic [10:0] tail_pos;
	logic [10:0] cksum_pos;
	logic [7:0]  sum_final;
	logic [15:0] rel_offset;
	logic [14:0] end_words;
	logic [13:0] end_capped;
	logic        emitted;
	kind_t       res_kind;

	// Common decode terms
	always_comb begin
		c              = item.rx_char;
		pos            = (cur.char_position == POS_MAX) ? cur.char_position
		                                                : cur.char_position + 10'd1;
		nib            = hex_nibble(c);
		eol            = (c == CHAR_CR) || (c == CHAR_LF);
		pair           = {cur.pending_nibble, nib};
		digits         = {cur.rec_length, 1'b0};
		shifted_offset = {cur.record_offset[11:0], nib};
		tail_pos       = 11'd9 + {2'b00, digits};
		cksum_pos      = tail_pos + 11'd1;
		sum_final      = cur.checksum_sum + pair;
		rel_offset     = cur.record_offset - base_address;
		end_words      = {1'b0, rel_offset[15:2]} + {9'b0, cur.rec_length[7:2]};
		end_capped     = (end_words > {1'b0, HW_CAP}) ? HW_CAP : end_words[13:0];
	end

	// Advance the parser by one character
	always_comb begin
		nxt       = cur;
		emitted   = 1'b0;
		res_kind  = KIND_DATA;
		res       = '0;
		if (item.receiving) begin
			if (c == CHAR_COLON) begin
				nxt.char_position   = 10'd0;
				nxt.data_char_index = 9'd0;
				nxt.record_kind     = REC_MUTED;
				nxt.checksum_sum    = 8'd0;
				nxt.pending_nibble  = 4'd0;
				nxt.aborted         = 1'b0;
			end else if (!cur.aborted) begin
				nxt.char_position = pos;
				res.byte_address  = cur.record_offset;
				if (pos == 10'd1 || pos == 10'd7) begin
					nxt.pending_nibble = nib;
				end else if (pos == 10'd2) begin
					nxt.rec_length   = pair;
					nxt.checksum_sum = cur.checksum_sum + pair;
				end else if (pos >= 10'd3 && pos <= 10'd6) begin
					nxt.record_offset = shifted_offset;
					if (pos == 10'd4 || pos == 10'd6) begin
						nxt.checksum_sum = cur.checksum_sum + shifted_offset[7:0];
					end
				end else if (pos == 10'd8) begin
					nxt.checksum_sum = cur.checksum_sum + pair;
					if (pair == 8'h00) begin
						nxt.record_kind = REC_DATA;
					end else if (pair == 8'h01) begin
						nxt.record_kind = REC_EOF;
					end else begin
						nxt.record_kind = REC_MUTED;
					end
				end else if (pos > 10'd8 && cur.record_kind != REC_MUTED) begin
					if (cur.data_char_index < digits) begin
						// Data digits
						nxt.data_char_index = cur.data_char_index + 9'd1;
						if (!cur.data_char_index[0]) begin
							nxt.pending_nibble = nib;
						end else begin
							nxt.checksum_sum = sum_final;
							if (cur.record_kind == REC_DATA) begin
								emitted          = 1'b1;
								res_kind         = KIND_DATA;
								res.data_value   = pair;
								res.byte_address = cur.record_offset
								                 + {8'b0, cur.data_char_index[8:1]};
							end
						end
					end else if ({1'b0, pos} == tail_pos) begin
						nxt.pending_nibble = nib;
					end else if ({1'b0, pos} == cksum_pos) begin
						// Checksum byte closes the record
						nxt.checksum_sum = sum_final;
						emitted          = 1'b1;
						if (sum_final != 8'd0) begin
							nxt.aborted     = 1'b1;
							nxt.record_kind = REC_MUTED;
							res_kind        = KIND_ERR;
						end else begin
							res_kind = KIND_OK;
							if (cur.record_kind == REC_DATA && end_capped > cur.high_water) begin
								nxt.high_water = end_capped;
							end
						end
					end
				end
				// Line end after an end-of-file record
				if (!emitted && nxt.record_kind == REC_EOF && eol) begin
					nxt.record_kind = REC_MUTED;
					nxt.aborted     = 1'b1;
					emitted         = 1'b1;
					res_kind        = KIND_DONE;
				end
			end
		end
		res.kind             = res_kind;
		res.high_water_words = nxt.high_water;
		res_valid            = emitted;
	end

endmodule

// File: src/hex_record_parser_core.sv
// Top level of the hex record parser: input stage, parser state, result register.
// Depends on hrp_pkg and hrp_decode.
//
// Usage:
//   The in channel takes one received character per transfer (in_data.receiving,
//   in_data.rx_char). Characters with receiving low change nothing.
//   The out channel delivers at most one result per character: a data byte with
//   its address, record ok, checksum error or transfer complete, each with the
//   current high-water word count.
//   The cfg channel writes base_address; cfg_ready is always high. Write it only
//   while no character is in flight.
// Timing:
//   A transferred character is held in the input register, decoded from it, and
//   its result is loaded into the output register, which drives out_valid and
//   out_data. One character is taken every cycle while out_ready does not stall
//   the output; the rate is set by the combinational decode between the input
//   and output registers.
// Reset:
//   arst_n clears the parser state, empties both stages and loads base_address
//   with 0x4000.
// Stall:
//   While out_valid is high and out_ready low, the output holds, the input stage
//   holds its character, and in_ready drops once that stage is occupied.
module hex_record_parser_core import hrp_pkg::*; #(
	parameter int BUFFER_WORDS = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int HW_CAP_INT = (BUFFER_WORDS > HW_LIMIT) ? HW_LIMIT : BUFFER_WORDS;
	localparam logic [13:0] HW_CAP = HW_CAP_INT[13:0];

	in_item_t     item_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic [15:0]  base_q;
	logic         out_valid_q;
	out_item_t    out_data_q;
	logic         res_valid;
	out_item_t    res;
	logic         slot_free;
	logic         advance;

	// Handshake control
	assign slot_free = !out_valid_q || out_ready;
	assign advance   = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	hrp_decode #(
		.HW_CAP(HW_CAP)
	) u_decode (
		.item        (item_s1),
		.cur         (state_q),
		.base_address(base_q),
		.nxt         (state_nxt),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Capture the input character on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Hold the result payload until a new one is produced
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	// Control state, parser state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			base_q      <= BASE_RESET;
			state_q     <= '{
				char_position:   10'd0,
				rec_length:      8'd0,
				record_offset:   16'd0,
				record_kind:     REC_MUTED,
				checksum_sum:    8'd0,
				pending_nibble:  4'd0,
				data_char_index: 9'd0,
				aborted:         1'b0,
				high_water:      14'd0
			};
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
		end
	end

endmodule

// File: bench/hex_record_parser_core_tb.sv
// Self-checking testbench for hex_record_parser_core: sends hex record text, predicts
// every result and checks it field by field; most tests idle either side at random.
// Depends on hrp_pkg and the parser RTL.
module hex_record_parser_core_tb import hrp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_WORDS  = 8192;
	localparam int WORD_CAP      = (BUFFER_WORDS < HW_LIMIT) ? BUFFER_WORDS : HW_LIMIT;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 6;

	// Record types as they appear in the text
	localparam logic [7:0] TYPE_DATA = 8'h00;
	localparam logic [7:0] TYPE_EOF  = 8'h01;

	// Line endings after a record
	localparam int END_NONE = 0;
	localparam int END_CR   = 1;
	localparam int END_LF   = 2;
	localparam int END_CRLF = 3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	// Parser state as the bench sees it
	logic [15:0] base_reg    = BASE_RESET;
	logic [9:0]  cur_pos     = '0;
	logic [7:0]  rec_len     = '0;
	logic [15:0] rec_offset  = '0;
	rec_kind_t   rec_class   = REC_MUTED;
	logic [7:0]  run_sum     = '0;
	logic [3:0]  hi_nib      = '0;
	logic [8:0]  data_digits = '0;
	logic        muted       = 1'b0;
	logic [13:0] words_high  = '0;

	out_item_t expected_results[$];
	int        mismatch_count = 0;
	int        chars_sent     = 0;
	int        send_idle_pct  = 0;
	int        stall_pct      = 0;

	hex_record_parser_core #(
		.BUFFER_WORDS(BUFFER_WORDS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ASCII hex digit to its value; anything else counts as zero
	function automatic logic [3:0] ascii_hex(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'h00;
		if (ch >= "0" && ch <= "9") begin
			v = ch - "0";
		end else if (ch >= "A" && ch <= "F") begin
			v = ch - "A" + 8'd10;
		end else if (ch >= "a" && ch <= "f") begin
			v = ch - "a" + 8'd10;
		end
		return v[3:0];
	endfunction

	// Advance the parser state by one character; return 1 with the result if one is due
	function automatic bit decode_char(input in_item_t item, output out_item_t res);
		logic [7:0]  ch;
		logic [3:0]  nib;
		logic [7:0]  b;
		logic [15:0] rel;
		logic        eol;
		int          digits;
		int          idx;
		int          k;
		int          start_w;
		int          end_w;
		res = '0;
		ch = item.rx_char;
		if (!item.receiving) begin
			return 1'b0;
		end
		// restart on a colon
		if (ch == CHAR_COLON) begin
			cur_pos = '0;
			data_digits = '0;
			rec_class = REC_MUTED;
			run_sum = '0;
			hi_nib = '0;
			muted = 1'b0;
			return 1'b0;
		end
		if (muted) begin
			return 1'b0;
		end
		if (cur_pos < POS_MAX) begin
			cur_pos = cur_pos + 1'b1;
		end
		nib = ascii_hex(ch);
		eol = (ch == CHAR_CR) || (ch == CHAR_LF);
		res.high_water_words = words_high;
		res.byte_address = rec_offset;

		// header: count, offset, type
		if (cur_pos == 1 || cur_pos == 7) begin
			hi_nib = nib;
		end else if (cur_pos == 2) begin
			rec_len = {hi_nib, nib};
			run_sum += rec_len;
		end else if (cur_pos >= 3 && cur_pos <= 6) begin
			rec_offset = {rec_offset[11:0], nib};
			if (cur_pos == 4 || cur_pos == 6) begin
				run_sum += rec_offset[7:0];
			end
		end else if (cur_pos == 8) begin
			b = {hi_nib, nib};
			run_sum += b;
			rec_class = (b == 8'h00) ? REC_DATA : (b == 8'h01) ? REC_EOF : REC_MUTED;
		end else if (rec_class != REC_MUTED) begin
			digits = 2 * rec_len;
			if (data_digits < digits) begin
				// data digits
				idx = int'(data_digits);
				data_digits = data_digits + 1'b1;
				if (idx % 2 == 0) begin
					hi_nib = nib;
				end else begin
					b = {hi_nib, nib};
					run_sum += b;
					if (rec_class == REC_DATA) begin
						res.kind = KIND_DATA;
						res.data_value = b;
						res.byte_address = rec_offset + 16'(idx / 2);
						return 1'b1;
					end
				end
			end else begin
				// checksum digits
				k = int'(cur_pos) - 9 - digits;
				if (k == 0) begin
					hi_nib = nib;
				end else if (k == 1) begin
					b = {hi_nib, nib};
					run_sum += b;
					if (run_sum != 8'h00) begin
						muted = 1'b1;
						rec_class = REC_MUTED;
						res.kind = KIND_ERR;
						return 1'b1;
					end
					if (rec_class == REC_DATA) begin
						rel = rec_offset - base_reg;
						start_w = int'(rel[15:2]);
						end_w = start_w + int'(rec_len[7:2]);
						if (end_w > WORD_CAP) begin
							end_w = WORD_CAP;
						end
						if (end_w > words_high) begin
							words_high = 14'(end_w);
						end
					end
					res.kind = KIND_OK;
					res.high_water_words = words_high;
					return 1'b1;
				end
			end
		end

		// line end after an end-of-file record
		if (rec_class == REC_EOF && eol) begin
			rec_class = REC_MUTED;
			muted = 1'b1;
			res.kind = KIND_DONE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Predict on each input transfer, check on each output transfer
	always @(posedge clk) begin
		out_item_t predicted;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (decode_char(in_data, predicted)) begin
					expected_results.push_back(predicted);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d, data_value %0h, byte_address %0h",
						out_data.kind, out_data.data_value, out_data.byte_address);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
						mismatch_count++;
					end
					if (out_data.data_value !== want.data_value) begin
						$error("data_value: expected %0h, got %0h",
							want.data_value, out_data.data_value);
						mismatch_count++;
					end
					if (out_data.byte_address !== want.byte_address) begin
						$error("byte_address: expected %0h, got %0h",
							want.byte_address, out_data.byte_address);
						mismatch_count++;
					end
					if (out_data.high_water_words !== want.high_water_words) begin
						$error("high_water_words: expected %0d, got %0d",
							want.high_water_words, out_data.high_water_words);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Receiver: stall at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Send one character; return at the edge of its transfer
	task automatic send_char(input logic rx_on, input logic [7:0] ch);
		in_item_t item;
		item.receiving = rx_on;
		item.rx_char = ch;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (rx_on) begin
			chars_sent++;
		end
	endtask

	// Send a received character, now and then behind one that arrives outside receive mode
	task automatic send_rx(input logic [7:0] ch);
		if ($urandom_range(15) == 0) begin
			send_char(1'b0, 8'($urandom));
		end
		send_char(1'b1, ch);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] letter;
		if (n < 4'd10) begin
			return "0" + n;
		end
		letter = $urandom_range(1) ? "A" : "a";
		return letter + n - 8'd10;
	endfunction

	// Send one record as text, maybe with a bad checksum, cut short or one bad character
	task automatic send_record(input int n_bytes, input logic [15:0] offset,
			input logic [7:0] rtype, input bit bad_sum, input int cut_at,
			input int ending, input bit corrupt);
		logic [7:0] bytes[$];
		logic [7:0] chars[$];
		logic [7:0] sum;
		int         i;
		bytes = {8'(n_bytes), offset[15:8], offset[7:0], rtype};
		for (i = 0; i < n_bytes; i++) begin
			bytes.push_back(8'($urandom));
		end
		sum = '0;
		foreach (bytes[j]) begin
			sum += bytes[j];
		end
		sum = -sum;
		if (bad_sum) begin
			sum ^= 8'($urandom_range(1, 255));
		end
		bytes.push_back(sum);
		chars.push_back(CHAR_COLON);
		foreach (bytes[j]) begin
			chars.push_back(hex_char(bytes[j][7:4]));
			chars.push_back(hex_char(bytes[j][3:0]));
		end
		if (ending == END_CR || ending == END_CRLF) begin
			chars.push_back(CHAR_CR);
		end
		if (ending == END_LF || ending == END_CRLF) begin
			chars.push_back(CHAR_LF);
		end
		if (cut_at > 0 && cut_at < chars.size()) begin
			chars = chars[0:cut_at-1];
		end
		if (corrupt && chars.size() > 1) begin
			chars[$urandom_range(1, chars.size() - 1)] = 8'($urandom);
		end
		foreach (chars[j]) begin
			send_rx(chars[j]);
		end
	endtask

	// Hold off until every expected result has come, then let the pipe settle
	task automatic drain_results();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatch_count += expected_results.size();
			expected_results.delete();
		end
	endtask

	task automatic write_base(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_reg = value;
	endtask

	// Random records: mostly well-formed, the rest broken, cut short or noise
	task automatic run_random_records(input int char_goal, input bit wild_offsets);
		int          start_count;
		int          pick;
		int          n;
		logic [15:0] off;
		logic [7:0]  ch;
		bit          paused;
		start_count = chars_sent;
		paused = 1'b0;
		while (chars_sent - start_count < char_goal) begin
			// pause once mid-phase until the output side catches up
			if (!paused && chars_sent - start_count >= char_goal / 2) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			n = ($urandom_range(15) == 0) ? $urandom_range(16, 64) : $urandom_range(0, 8);
			if (wild_offsets && $urandom_range(1)) begin
				off = 16'($urandom);
			end else begin
				off = base_reg + 16'($urandom_range(0, 16'h3FFF));
			end
			if ($urandom_range(11) == 0) begin
				off = 16'hFFFF - 16'($urandom_range(3));
			end
			if (pick < 55) begin
				send_record(n, off, TYPE_DATA, $urandom_range(9) == 0, 0,
					$urandom_range(END_CRLF), $urandom_range(19) == 0);
			end else if (pick < 67) begin
				send_record($urandom_range(2), off, TYPE_EOF, $urandom_range(7) == 0, 0,
					$urandom_range(END_CRLF), $urandom_range(19) == 0);
			end else if (pick < 75) begin
				send_record(n, off, 8'($urandom_range(2, 255)), 1'b0, 0,
					$urandom_range(END_CRLF), 1'b0);
			end else if (pick < 85) begin
				send_record(n, off, $urandom_range(1) ? TYPE_DATA : TYPE_EOF, 1'b0,
					$urandom_range(1, 11 + 2 * n), END_NONE, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(3))
						0: ch = CHAR_CR;
						1: ch = CHAR_LF;
						2: ch = CHAR_COLON;
						default: ch = 8'($urandom);
					endcase
					send_rx(ch);
				end
			end
		end
	endtask

	// Text before any colon, a two-byte data record, an end-of-file record
	task automatic test_directed_records();
		send_char(1'b1, 8'hFF);
		send_char(1'b0, 8'h00);
		send_record(2, 16'h4010, TYPE_DATA, 1'b0, 0, END_NONE, 1'b0);
		send_record(0, 16'h0000, TYPE_EOF, 1'b0, 0, END_LF, 1'b0);
		drain_results();
	endtask

	// Base zero, no idling, random records, then one record of the largest size
	task automatic test_no_idle();
		send_idle_pct = 0;
		stall_pct = 0;
		write_base(16'h0000);
		run_random_records(250, 1'b0);
		send_record(255, base_reg + 16'h0100, TYPE_DATA, 1'b0, 0, END_CRLF, 1'b0);
		drain_results();
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 87;
		stall_pct = 0;
		write_base(16'($urandom));
		run_random_records(300, 1'b0);
		drain_results();
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		stall_pct = 87;
		write_base(16'hFFFF);
		run_random_records(300, 1'b0);
		drain_results();
	endtask

	// Both sides idle; offsets anywhere, so the high-water count saturates
	task automatic test_mixed_idle();
		send_idle_pct = 18;
		stall_pct = 18;
		write_base(16'($urandom));
		run_random_records(300, 1'b1);
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_records();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_mixed_idle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
